// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define WFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wfa check failed");

// Concurrent check that also holds through reset.
`define WFA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("wfa check failed");

`endif

// ===== src/wfa_pkg.sv =====
package wfa_pkg;

   localparam int unsigned Q15_ONE    = 32768;
   localparam int unsigned MAX_FRAMES = 65536;
   localparam int unsigned PI_Q16     = 205887;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned FRAME_W    = 17;
   localparam int unsigned CSR_DATA_W = 17;
   localparam int unsigned W_W        = 17;   // window value, -1.0..+1.0 in Q1.15
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned T_W        = 24;   // normalized position, Q24
   localparam int unsigned ANG_W      = 26;   // angle, Q26 turns

   typedef enum logic [1:0] {
      CSR_WINDOW_TYPE = 2'd0,
      CSR_FRAME_COUNT = 2'd1,
      CSR_REVERSE     = 2'd2,
      CSR_MULTIPLY    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      WIN_BARTLETT = 3'd0,
      WIN_SINE     = 3'd1,
      WIN_HANN     = 3'd2,
      WIN_HAMMING  = 3'd3,
      WIN_BLACKMAN = 3'd4,
      WIN_CONNES   = 3'd5,
      WIN_WELCH    = 3'd6,
      WIN_LANCZOS  = 3'd7
   } window_kind_type;

   // Shift right by s, rounding half away from zero.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic [63:0] half;
      logic [63:0] mag;
      logic [63:0] q;
      half = 64'd1 << (s - 1);
      mag  = v[63] ? 64'(-v) : 64'(v);
      q    = (mag + half) >> s;
      return v[63] ? -signed'(q) : signed'(q);
   endfunction

   // Clamp to [-1.0, +1.0] in Q1.15.
   function automatic logic signed [W_W-1:0] clamp_q15(input logic signed [63:0] v);
      if (v > 64'sd32768)
         return signed'(W_W'(Q15_ONE));
      else if (v < -64'sd32768)
         return -signed'(W_W'(Q15_ONE));
      else
         return v[W_W-1:0];
   endfunction

endpackage

// ===== src/wfa_divider.sv =====
module wfa_divider import wfa_pkg::*; #(
   parameter int DW = 17,
   parameter int QW = 24,
   parameter int SW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,     // partial remainder, below in_div
   input  logic [QW-1:0] in_bits,    // dividend bits still to shift in, MSB first
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   // One quotient bit per stage, restoring.
   logic [QW-1:0] valid_ff;
   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] bits_ff [QW];
   logic [QW-1:0] bits_in [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [DW-1:0] div_ff  [QW];
   logic [DW-1:0] div_in  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [SW-1:0] side_in [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] p_rem;
      logic [QW-1:0] p_bits;
      logic [QW-1:0] p_quo;
      logic [DW+1:0] diff;
      logic          ge;

      if (i == 0) begin : g_head
         assign p_rem      = in_rem;
         assign p_bits     = in_bits;
         assign p_quo      = '0;
         assign div_in[i]  = in_div;
         assign side_in[i] = in_side;
      end else begin : g_body
         assign p_rem      = rem_ff[i-1];
         assign p_bits     = bits_ff[i-1];
         assign p_quo      = quo_ff[i-1];
         assign div_in[i]  = div_ff[i-1];
         assign side_in[i] = side_ff[i-1];
      end

      always_comb begin
         diff       = {1'b0, p_rem, p_bits[QW-1]} - {2'b00, div_in[i]};
         ge         = !diff[DW+1];
         rem_in[i]  = ge ? diff[DW-1:0] : {p_rem[DW-2:0], p_bits[QW-1]};
         bits_in[i] = {p_bits[QW-2:0], 1'b0};
         quo_in[i]  = {p_quo[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in[i];
            bits_ff[i] <= bits_in[i];
            quo_ff[i]  <= quo_in[i];
            div_ff[i]  <= div_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== src/wfa_cos.sv =====
module wfa_cos import wfa_pkg::*; #(
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [1:0][ANG_W-1:0]   angle,     // Q26 turns, two lanes
   output logic [1:0][W_W-1:0]     cos_val    // signed Q1.15, after the k, m and ROM registers
);

   localparam int FOUR_D = 4 * COS_TABLE_DEPTH;
   localparam int KW     = $clog2(FOUR_D + 1);
   localparam int MW     = $clog2(COS_TABLE_DEPTH + 1);
   localparam int PW     = ANG_W + KW;

   typedef logic [COS_TABLE_DEPTH:0][15:0] rom_type;

   // Quarter-wave sine, odd degree-9 polynomial in Q30, rounded to Q15.
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned acc;
      longint unsigned r;
      for (int m = 0; m <= COS_TABLE_DEPTH; m++) begin
         z   = (longint'(m) << 30) / COS_TABLE_DEPTH;
         z2  = (z * z) >> 30;
         acc = 172272;
         acc = 5026995 - ((acc * z2) >> 30);
         acc = 85569305 - ((acc * z2) >> 30);
         acc = 693598775 - ((acc * z2) >> 30);
         acc = 1686629713 - ((acc * z2) >> 30);
         r   = (((acc * z) >> 30) + (64'd1 << 14)) >> 15;
         if (r > Q15_ONE)
            r = Q15_ONE;
         rom[m] = 16'(r);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [PW-1:0] prod;
      logic [PW-1:0] krnd;
      logic [KW-1:0] k_in;
      logic [KW-1:0] k_ff;
      logic [MW-1:0] m_in;
      logic [MW-1:0] m_ff;
      logic          neg_in;
      logic          neg_ff;
      logic          neg2_ff;
      logic [15:0]   rom_ff;

      // Angle to table step, rounded, wrapped at one turn.
      always_comb begin
         prod = PW'(angle[l]) * PW'(FOUR_D);
         krnd = (prod + (PW'(1) << (ANG_W - 1))) >> ANG_W;
         k_in = (krnd[KW-1:0] == KW'(FOUR_D)) ? '0 : krnd[KW-1:0];
      end

      // Quadrant fold onto the quarter wave.
      always_comb begin
         if (k_ff >= KW'(3 * COS_TABLE_DEPTH)) begin
            m_in   = MW'(k_ff - KW'(3 * COS_TABLE_DEPTH));
            neg_in = 1'b0;
         end else if (k_ff >= KW'(2 * COS_TABLE_DEPTH)) begin
            m_in   = MW'(KW'(3 * COS_TABLE_DEPTH) - k_ff);
            neg_in = 1'b1;
         end else if (k_ff >= KW'(COS_TABLE_DEPTH)) begin
            m_in   = MW'(k_ff - KW'(COS_TABLE_DEPTH));
            neg_in = 1'b1;
         end else begin
            m_in   = MW'(KW'(COS_TABLE_DEPTH) - k_ff);
            neg_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            k_ff    <= k_in;
            m_ff    <= m_in;
            neg_ff  <= neg_in;
            rom_ff  <= SINE_ROM[m_ff];
            neg2_ff <= neg_ff;
         end
      end

      assign cos_val[l] = neg2_ff ? W_W'(-{1'b0, rom_ff}) : {1'b0, rom_ff};
   end

endmodule

// ===== src/window_function_apply_core.sv =====
// Channel  Dir  tdata (low bit up)                   tuser
// req_     in   position[15:0], sample_in[SB-1:0]    -
// rsp_     out  result_value[16:0], zero pad to 24   index_error
// csr_     in   csr_we / csr_index / csr_wdata[16:0], write only
//
// One request per cycle unless the output register is held. Path: position divider,
// shaping stages B-F, Lanczos divider, then window select, product and output (G, H, I).
// One pipeline enable: all stages move unless the output register is held.
// reset (synchronous) clears valid bits and CSRs; payload is not reset.
// CSRs must only be written with the pipeline empty.
module window_function_apply_core import wfa_pkg::*; #(
   parameter  int SAMPLE_BITS     = 16,
   parameter  int COS_TABLE_DEPTH = 1024,
   localparam int REQ_DATA_W      = ((POS_W + SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // position, sample_in
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // result_value
   output logic                   rsp_tuser,   // index_error
   // CSR write port
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SB   = SAMPLE_BITS;
   localparam int D1_S = 1 + SB;              // err, sample
   localparam int D2_S = 1 + SB + W_W + 2;    // err, sample, w, ovf, sign
   localparam int DEN_W = 43;
   localparam int LQ_W  = 17;                 // Lanczos quotient bits
   localparam logic [ANG_W-1:0] QUARTER = ANG_W'(1) << 24;

   // ---------------- CSRs ----------------
   window_kind_type        window_type_ff;
   logic [FRAME_W-1:0]     frame_count_ff;
   logic                   reverse_ff;
   logic                   multiply_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_type_ff <= WIN_BARTLETT;
         frame_count_ff <= FRAME_W'(1024);
         reverse_ff     <= 1'b0;
         multiply_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_TYPE: window_type_ff <= window_kind_type'(csr_wdata[2:0]);
            CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[FRAME_W-1:0];
            CSR_REVERSE:     reverse_ff     <= csr_wdata[0];
            CSR_MULTIPLY:    multiply_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic rsp_tvalid_ff;
   logic adv;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- position divider: t = (2p+1)*2^23 / F ----------------
   logic [POS_W-1:0]    pos;
   logic signed [SB-1:0] samp;
   logic                err_in;
   logic [FRAME_W-1:0]  f_eff;
   logic                d1_valid;
   logic [T_W-1:0]      d1_t;
   logic [D1_S-1:0]     d1_side;

   assign pos    = req_tdata[POS_W-1:0];
   assign samp   = req_tdata[POS_W +: SB];
   assign err_in = {1'b0, pos} >= frame_count_ff;
   assign f_eff  = (frame_count_ff > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES)
                                                         : frame_count_ff;

   // Remainder starts at p; the shifted-in dividend bits are 1 then zeros.
   wfa_divider #(.DW(FRAME_W), .QW(T_W), .SW(D1_S)) u_pos_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (req_tvalid),
      .in_rem   ({1'b0, pos}),
      .in_bits  ({1'b1, {(T_W-1){1'b0}}}),
      .in_div   (f_eff),
      .in_side  ({err_in, samp}),
      .out_valid(d1_valid),
      .out_quo  (d1_t),
      .out_side (d1_side)
   );

   // ---------------- angles into the cosine lookup ----------------
   logic [ANG_W-1:0]       t26;
   logic [24:0]            v25;
   logic [1:0][ANG_W-1:0]  angle;
   logic [1:0][W_W-1:0]    cos_val;

   always_comb begin
      t26 = ANG_W'(d1_t);
      v25 = {1'b0, d1_t} + (reverse_ff ? 25'd0 : 25'(QUARTER));
      case (window_type_ff)
         WIN_SINE:
            angle[0] = reverse_ff ? t26 : t26 + ANG_W'(3 * QUARTER);
         WIN_HANN, WIN_HAMMING, WIN_BLACKMAN:
            angle[0] = (t26 << 1) + (reverse_ff ? '0 : ANG_W'(2 * QUARTER));
         WIN_LANCZOS:
            angle[0] = (ANG_W'(v25) << 1) + ANG_W'(3 * QUARTER);
         default:
            angle[0] = '0;
      endcase
      angle[1] = t26 << 2;   // Blackman second harmonic
   end

   wfa_cos #(.COS_TABLE_DEPTH(COS_TABLE_DEPTH)) u_cos (
      .clock  (clock),
      .enable (adv),
      .angle  (angle),
      .cos_val(cos_val)
   );

   // ---------------- stage B: x, v, Bartlett ----------------
   logic                 b_valid_ff, b_err_ff;
   logic signed [SB-1:0] b_samp_ff;
   logic [24:0]          b_x_ff, b_x_in, b_v_ff;
   logic signed [W_W-1:0] b_bart_ff, b_bart_in;
   logic [24:0]          tq_sum;
   logic [15:0]          tq;

   always_comb begin
      b_x_in    = {1'b0, d1_t} + (reverse_ff ? 25'(QUARTER) : 25'd0);
      tq_sum    = {1'b0, d1_t} + 25'd256;
      tq        = tq_sum[24:9];
      b_bart_in = reverse_ff ? signed'(W_W'(Q15_ONE) - W_W'(tq)) : signed'(W_W'(tq));
   end

   // ---------------- stage C: squares and Lanczos denominator ----------------
   logic                 c_valid_ff, c_err_ff;
   logic signed [SB-1:0] c_samp_ff;
   logic signed [W_W-1:0] c_bart_ff;
   logic [49:0]          c_xx_ff;
   logic [DEN_W-1:0]     c_den_ff;

   // ---------------- stage D: Welch and the Connes base ----------------
   logic                 d_valid_ff, d_err_ff;
   logic signed [SB-1:0] d_samp_ff;
   logic signed [W_W-1:0] d_bart_ff, d_welch_ff;
   logic signed [26:0]   d_g24_ff;
   logic [DEN_W-1:0]     d_den_ff;
   logic signed [63:0]   g64;
   logic signed [63:0]   g24_full;

   always_comb begin
      g64      = (64'sd1 <<< 48) - signed'(64'(c_xx_ff));   // 1 - x^2 in Q48
      g24_full = round_shift(g64, 24);
   end

   // ---------------- stage E: cosine shapes ----------------
   logic                 e_valid_ff, e_err_ff;
   logic signed [SB-1:0] e_samp_ff;
   logic signed [W_W-1:0] e_bart_ff, e_welch_ff, e_wcos_ff, e_wcos_in;
   logic [53:0]          e_conn_ff;
   logic signed [53:0]   conn_sq;
   logic [15:0]          e_mag_ff, mag_in;
   logic                 e_sneg_ff;
   logic [DEN_W-1:0]     e_den_ff;
   logic signed [63:0]   c1, c2, w_cos;

   always_comb begin
      c1      = 64'(signed'(cos_val[0]));
      c2      = 64'(signed'(cos_val[1]));
      conn_sq = d_g24_ff * d_g24_ff;
      mag_in  = c1[63] ? 16'(-c1) : 16'(c1);
      case (window_type_ff)
         WIN_HANN:     w_cos = round_shift(64'sd32768 + c1, 1);
         WIN_HAMMING:  w_cos = round_shift(64'sd35389 * 64'sd32768 + 64'sd30147 * c1, 16);
         WIN_BLACKMAN: w_cos = round_shift(64'sd27525 * 64'sd32768 + 64'sd32768 * c1
                                           + 64'sd5243 * c2, 16);
         default:      w_cos = c1;
      endcase
      e_wcos_in = clamp_q15(w_cos);
   end

   // ---------------- stage F: polynomial select, Lanczos dividend ----------------
   logic                 f_valid_ff, f_err_ff;
   logic signed [SB-1:0] f_samp_ff;
   logic signed [W_W-1:0] f_wpoly_ff, f_wpoly_in;
   logic [DEN_W-1:0]     f_rem_ff, f_den_ff;
   logic [LQ_W-1:0]      f_low_ff;
   logic                 f_ovf_ff, f_sneg_ff;
   logic [55:0]          lz_num;
   logic [DEN_W-1:0]     lz_r0;
   logic                 lz_ovf;

   always_comb begin
      case (window_type_ff)
         WIN_BARTLETT: f_wpoly_in = e_bart_ff;
         WIN_WELCH:    f_wpoly_in = e_welch_ff;
         WIN_CONNES:   f_wpoly_in = clamp_q15(round_shift(signed'(64'(e_conn_ff)), 33));
         default:      f_wpoly_in = e_wcos_ff;
      endcase
      // (|s| * 2^40 + den/2), quotient at or above 2^17 clamps via the overflow flag
      lz_num = (56'(e_mag_ff) << 40) + 56'(e_den_ff >> 1);
      lz_r0  = DEN_W'(lz_num[55:LQ_W]);
      lz_ovf = lz_r0 >= e_den_ff;
   end

   // ---------------- Lanczos divider ----------------
   logic                 l_valid;
   logic [LQ_W-1:0]      l_quo;
   logic [D2_S-1:0]      l_side;

   wfa_divider #(.DW(DEN_W), .QW(LQ_W), .SW(D2_S)) u_lz_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (f_valid_ff),
      .in_rem   (f_rem_ff),
      .in_bits  (f_low_ff),
      .in_div   (f_den_ff),
      .in_side  ({f_err_ff, f_samp_ff, f_wpoly_ff, f_ovf_ff, f_sneg_ff}),
      .out_valid(l_valid),
      .out_quo  (l_quo),
      .out_side (l_side)
   );

   // ---------------- stage G: window select ----------------
   logic                 g_valid_ff, g_err_ff;
   logic signed [SB-1:0] g_samp_ff;
   logic signed [W_W-1:0] g_w_ff, g_w_in;
   logic                 l_err, l_ovf, l_sneg;
   logic signed [SB-1:0] l_samp;
   logic signed [W_W-1:0] l_wpoly;
   logic [W_W-1:0]       l_qv;

   always_comb begin
      {l_err, l_samp, l_wpoly, l_ovf, l_sneg} = l_side;
      l_qv   = (l_ovf || l_quo > LQ_W'(Q15_ONE)) ? W_W'(Q15_ONE) : W_W'(l_quo);
      g_w_in = (window_type_ff == WIN_LANCZOS) ? (l_sneg ? -signed'(l_qv) : signed'(l_qv))
                                                 : l_wpoly;
   end

   // ---------------- stage H: product ----------------
   logic                  h_valid_ff, h_err_ff;
   logic signed [W_W-1:0] h_w_ff;
   logic signed [SB+W_W-1:0] h_prod_ff;

   // ---------------- stage I: output register ----------------
   logic [W_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                 rsp_err_ff;
   logic signed [63:0]   prod_rnd;

   always_comb begin
      prod_rnd = round_shift(64'(h_prod_ff), 15);
      if (h_err_ff)
         rsp_data_in = '0;
      else if (multiply_ff)
         rsp_data_in = prod_rnd[W_W-1:0];
      else
         rsp_data_in = h_w_ff;
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         f_valid_ff    <= 1'b0;
         g_valid_ff    <= 1'b0;
         h_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff    <= d1_valid;
         c_valid_ff    <= b_valid_ff;
         d_valid_ff    <= c_valid_ff;
         e_valid_ff    <= d_valid_ff;
         f_valid_ff    <= e_valid_ff;
         g_valid_ff    <= l_valid;
         h_valid_ff    <= g_valid_ff;
         rsp_tvalid_ff <= h_valid_ff;
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         {b_err_ff, b_samp_ff} <= d1_side;
         b_x_ff     <= b_x_in;
         b_v_ff     <= v25;
         b_bart_ff  <= b_bart_in;

         c_err_ff   <= b_err_ff;
         c_samp_ff  <= b_samp_ff;
         c_bart_ff  <= b_bart_ff;
         c_xx_ff    <= b_x_ff * b_x_ff;
         c_den_ff   <= DEN_W'(b_v_ff) * DEN_W'(PI_Q16);

         d_err_ff   <= c_err_ff;
         d_samp_ff  <= c_samp_ff;
         d_bart_ff  <= c_bart_ff;
         d_welch_ff <= clamp_q15(round_shift(g64, 33));
         d_g24_ff   <= g24_full[26:0];
         d_den_ff   <= c_den_ff;

         e_err_ff   <= d_err_ff;
         e_samp_ff  <= d_samp_ff;
         e_bart_ff  <= d_bart_ff;
         e_welch_ff <= d_welch_ff;
         e_wcos_ff  <= e_wcos_in;
         e_conn_ff  <= 54'(conn_sq);
         e_mag_ff   <= mag_in;
         e_sneg_ff  <= c1[63];
         e_den_ff   <= d_den_ff;

         f_err_ff   <= e_err_ff;
         f_samp_ff  <= e_samp_ff;
         f_wpoly_ff <= f_wpoly_in;
         f_rem_ff   <= lz_ovf ? '0 : lz_r0;
         f_low_ff   <= lz_num[LQ_W-1:0];
         f_den_ff   <= e_den_ff;
         f_ovf_ff   <= lz_ovf;
         f_sneg_ff  <= e_sneg_ff && (e_den_ff != '0);   // zero argument gives +1

         g_err_ff   <= l_err;
         g_samp_ff  <= l_samp;
         g_w_ff     <= g_w_in;

         h_err_ff   <= g_err_ff;
         h_w_ff     <= g_w_ff;
         h_prod_ff  <= g_samp_ff * g_w_ff;

         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= h_err_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-W_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

// ===== src/wfa_checker.sv =====
`include "assert_macros.svh"

module wfa_checker import wfa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // flagged request carries a zero result
   `WFA_ASSERT(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[16:0] == '0)

   // result stays within -1.0..+1.0
   `WFA_ASSERT(a_range, clock, reset, rsp_tvalid |-> (rsp_tdata[16] == rsp_tdata[15]) || (rsp_tdata[16:0] == 17'h08000))

   // held result does not change
   `WFA_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // pipeline takes requests whenever the output is free to move
   `WFA_ASSERT(a_flow, clock, reset, !rsp_tvalid || rsp_tready |-> req_tready)

   // reset empties the pipeline
   `WFA_ASSERT_ALWAYS(a_reset, clock, $past(reset) |-> !rsp_tvalid)

endmodule

bind window_function_apply_core wfa_checker u_wfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
